[src/fifn_pkg.sv]
// Package for the flow integer field narrower.
// Holds the transaction structs and destination kind codes; no dependencies.
package fifn_pkg;

    localparam int unsigned RAW_W   = 64;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned KIND_W  = 4;
    localparam int unsigned MAX_BYTES = RAW_W / 8;

    localparam logic [KIND_W-1:0] KIND_U8   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_U16  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_U32  = 4'd2;
    localparam logic [KIND_W-1:0] KIND_U64  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_I8   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_I16  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_I32  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_I64  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_CHAR = 4'd8;

    localparam logic [RAW_W-1:0] W8_MASK  = 64'h0000_0000_0000_00FF;
    localparam logic [RAW_W-1:0] W16_MASK = 64'h0000_0000_0000_FFFF;
    localparam logic [RAW_W-1:0] W32_MASK = 64'h0000_0000_FFFF_FFFF;
    localparam logic [RAW_W-1:0] W64_MASK = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [RAW_W-1:0]   raw_bytes;
        logic [COUNT_W-1:0] byte_count;
        logic               source_signed;
        logic [KIND_W-1:0]  dest_kind;
        logic               wrap_not_clamp;
    } field_in_t;

    typedef struct packed {
        logic [RAW_W-1:0] converted_bits;
        logic             convert_error;
    } field_out_t;

endpackage

[src/flow_integer_field_narrower_top.sv]
// Flow integer field narrower, top level.
// Registers one field, narrows it to the destination type, registers the result.
// Depends on fifn_pkg.
//
//  channel  | handshake        | payload
//  ---------+------------------+---------------------
//  input    | start, busy      | item   (field_in_t)
//  result   | done (strobe)    | result (field_out_t)
//
// One transaction per cycle; busy never rises.
// Path: input register, then narrowing logic into the result register.
// Reset clears both valid flags; payload registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle with done.
module flow_integer_field_narrower_top
    import fifn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  field_in_t  item,
    output logic       done,
    output field_out_t result
);

    logic       valid_reg;
    field_in_t  item_reg;
    logic       done_reg;
    field_out_t result_reg;
    field_out_t result_next;

    logic [RAW_W-1:0]   byte_mask;
    logic               src_sign;
    logic [RAW_W-1:0]   v;
    logic [RAW_W-1:0]   dmask;
    logic [RAW_W-1:0]   half;
    logic               dst_signed;
    logic               bad;
    logic               neg;
    logic               fits_s;
    logic [RAW_W-1:0]   umax;
    logic [RAW_W-1:0]   res;

    assign busy = 1'b0;

    always_comb
    begin
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            byte_mask[i*8 +: 8] = (COUNT_W'(i) < item_reg.byte_count) ? 8'hFF : 8'h00;
        end
        src_sign = 1'b0;
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            if (item_reg.byte_count == COUNT_W'(i + 1))
                src_sign = item_reg.raw_bytes[i*8 + 7];
        end
        v = item_reg.raw_bytes & byte_mask;
        if (item_reg.source_signed && src_sign)
            v = v | ~byte_mask;

        bad        = 1'b0;
        dst_signed = 1'b0;
        dmask      = W8_MASK;
        unique case (item_reg.dest_kind) inside
            KIND_U8:   dmask = W8_MASK;
            KIND_U16:  dmask = W16_MASK;
            KIND_U32:  dmask = W32_MASK;
            KIND_U64:  dmask = W64_MASK;
            KIND_I8:   begin dmask = W8_MASK;  dst_signed = 1'b1; end
            KIND_I16:  begin dmask = W16_MASK; dst_signed = 1'b1; end
            KIND_I32:  begin dmask = W32_MASK; dst_signed = 1'b1; end
            KIND_I64:  begin dmask = W64_MASK; dst_signed = 1'b1; end
            KIND_CHAR: begin dmask = W8_MASK;  dst_signed = item_reg.source_signed; end
            default:   bad = 1'b1;
        endcase
        if (item_reg.byte_count == '0 || item_reg.byte_count > COUNT_W'(MAX_BYTES))
            bad = 1'b1;

        half   = dmask >> 1;
        neg    = v[RAW_W-1];
        fits_s = ((v & ~half) == '0) || ((v & ~half) == ~half);
        umax   = dst_signed ? half : dmask;

        res = v & dmask;
        if (!item_reg.wrap_not_clamp)
        begin
            if (item_reg.source_signed && dst_signed)
            begin
                if (!fits_s)
                    res = neg ? (dmask ^ half) : half;
            end
            else if (item_reg.source_signed)
            begin
                if (neg)
                    res = '0;
                else if ((v & ~dmask) != '0)
                    res = dmask;
            end
            else if ((v & ~umax) != '0)
            begin
                res = umax;
            end
        end

        result_next.converted_bits = bad ? '0 : (res & dmask);
        result_next.convert_error  = bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= start && !busy;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            item_reg <= item;
        if (valid_reg)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("done without a start two cycles earlier");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.convert_error |-> result.converted_bits == '0)
        else $error("error result carries nonzero bits");

    a_narrow_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (item_reg.dest_kind == KIND_U8 || item_reg.dest_kind == KIND_I8
                      || item_reg.dest_kind == KIND_CHAR)
        |=> result.converted_bits[RAW_W-1:8] == '0)
        else $error("8-bit destination has upper bits set");

endmodule
